// ===== hdl/ptlf_pkg.sv =====
`default_nettype none

package ptlf_pkg;

    // Field widths
    localparam int MEAN_W   = 20;
    localparam int VAR_W    = 24;
    localparam int FRAC_W   = 16;
    localparam int LEXP_W   = 16;
    localparam int MINZ_W   = 6;
    localparam int R2_W     = 17;
    localparam int ZST_W    = 3;
    localparam int FST_W    = 2;
    localparam int NZ_W     = 6;
    localparam int SLOPE_W  = 32;
    localparam int ICPT_W   = 36;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;

    // Shared arithmetic datapath
    localparam int DP_W   = 128;
    localparam int WORD_W = 64;
    localparam int CNT_W  = $clog2(DP_W + 1);

    localparam int MAX_ZONES_DEF = 32;

    // Register reset values
    localparam logic signed [LEXP_W-1:0] MIN_LEXP_RST  = -16'sd6554;
    localparam logic [MINZ_W-1:0]        MIN_ZONES_RST = 6'd5;
    localparam logic [R2_W-1:0]          MIN_R2_RST    = 17'd58982;

    // Saturation limits
    localparam logic [SLOPE_W-1:0] SLOPE_CAP_POS = 32'h7FFF_FFFF;
    localparam logic [SLOPE_W-1:0] SLOPE_CAP_NEG = 32'h8000_0000;
    localparam logic [ICPT_W-1:0]  ICPT_CAP_POS  = 36'h7_FFFF_FFFF;
    localparam logic [ICPT_W-1:0]  ICPT_CAP_NEG  = 36'h8_0000_0000;
    localparam logic [R2_W-1:0]    R2_ONE        = 17'h1_0000;
    localparam logic [MINZ_W-1:0]  MIN_ZONES_FLOOR = 6'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEXP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ZONES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_R2    = 2'd2;

    typedef enum logic [ZST_W-1:0] {
        ZS_INCLUDED    = 3'd0,
        ZS_NO_VARIANCE = 3'd1,
        ZS_SATURATED   = 3'd2,
        ZS_BELOW_BLACK = 3'd3,
        ZS_LOW_TAIL    = 3'd4,
        ZS_NONPOS_MEAN = 3'd5
    } zone_status_t;

    typedef enum logic [FST_W-1:0] {
        FS_OK         = 2'd0,
        FS_TOO_FEW    = 2'd1,
        FS_NOT_LINEAR = 2'd2
    } fit_status_t;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } mdu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_XX,
        S_ACC_XY,
        S_ACC_YY,
        S_FIT_CHECK,
        S_SXX_A,
        S_SXX_B,
        S_SYY_A,
        S_SYY_B,
        S_SXY_A,
        S_SXY_B,
        S_SLOPE,
        S_ICPT_MUL,
        S_ICPT_DIV,
        S_R2_NUM,
        S_R2_DEN,
        S_R2_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        mdu_op_t           op;
        logic [DP_W-1:0]   a;
        logic [DP_W-1:0]   b;
    } mdu_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DP_W-1:0]   result;
    } mdu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/ptlf_mdu.sv =====
`default_nettype none

// Shared multiply / divide unit.
// MUL: shift-add, one multiplier bit per cycle, stops when the multiplier runs out.
// DIV: restoring, one quotient bit per cycle, then one round-half-up step.
module ptlf_mdu
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptlf_pkg::mdu_req_t req,
    output ptlf_pkg::mdu_rsp_t      rsp
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    ptlf_pkg::mdu_op_t             op_reg, op_next;
    logic [ptlf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ptlf_pkg::DP_W-1:0]     acc_reg, acc_next;
    logic [ptlf_pkg::DP_W-1:0]     a_reg, a_next;
    logic [ptlf_pkg::DP_W-1:0]     b_reg, b_next;
    logic [ptlf_pkg::DP_W-1:0]     rem_reg, rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        logic [ptlf_pkg::DP_W:0] rem_sh;
        logic [ptlf_pkg::DP_W:0] div_ext;

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, a_reg[ptlf_pkg::DP_W-1]};
        div_ext   = {1'b0, b_reg};

        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                cnt_next  = '0;
                acc_next  = '0;
                a_next    = req.a;
                b_next    = req.b;
                rem_next  = '0;
            end
        end
        else
        begin
            case (op_reg)
                ptlf_pkg::MDU_MUL:
                begin
                    if (b_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (b_reg[0])
                            acc_next = acc_reg + a_reg;
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                end
                ptlf_pkg::MDU_DIV:
                begin
                    if (cnt_reg == ptlf_pkg::CNT_W'(ptlf_pkg::DP_W))
                    begin
                        // round half up on the final remainder
                        if ({rem_reg, 1'b0} >= div_ext)
                            acc_next = acc_reg + 1'b1;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        a_next = a_reg << 1;
                        if (rem_sh >= div_ext)
                        begin
                            rem_next = ptlf_pkg::DP_W'(rem_sh - div_ext);
                            acc_next = {acc_reg[ptlf_pkg::DP_W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_next = rem_sh[ptlf_pkg::DP_W-1:0];
                            acc_next = {acc_reg[ptlf_pkg::DP_W-2:0], 1'b0};
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/photon_transfer_line_fit.sv =====
`default_nettype none

// Photon transfer line fit for one color plane.
// Input stream (s_*): one zone record per item, s_tlast marks the last zone of
// the plane. Output stream (m_*): one result item per input item, carrying the
// zone classification and, on the last zone (m_tuser high), the fitted line.
// Config port: cfg_we/cfg_index/cfg_data, to be written only while the block is
// idle; the block itself does not enforce this. An excluded, non-last zone goes
// from idle to the output state, which loads the output register once it is
// free and returns to idle. An included zone runs three shift-add products
// (x*x, x*y, y*y) in the shared multiply/divide unit, one multiplier bit per
// cycle. A last zone adds the fit: up to nine more products and three restoring
// divides. The block takes one item at a time; s_tready is high only while the
// sequencer is idle.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the finished result of the following item
// holds in the sequencer until the output register frees up.
// Reset clears the sums and zone count, loads the register defaults and
// empties the output register.
module photon_transfer_line_fit
#(
    parameter int MAX_ZONES = ptlf_pkg::MAX_ZONES_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // mean_level[19:0], noise_variance[43:20], samples_present[44],
    // saturated_part[60:45], below_black_part[76:61], lexp[92:77]
    input  wire logic [ptlf_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // zone_status[2:0], fit_status[4:3], fitted_zones[10:5], fit_slope[42:11],
    // fit_intercept[78:43], fit_r_squared[95:79]
    output logic [ptlf_pkg::M_TDATA_W-1:0]         m_tdata,
    // fit_ready[0]
    output logic                                   m_tuser,
    input  wire logic                              cfg_we,
    input  wire logic [ptlf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ptlf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LW      = $clog2(MAX_ZONES);
    localparam int CW      = $clog2(MAX_ZONES + 1);
    localparam int SX_W    = ptlf_pkg::MEAN_W + LW;
    localparam int SY_W    = ptlf_pkg::VAR_W + LW;
    localparam int SXX2_W  = 2 * ptlf_pkg::MEAN_W + LW;
    localparam int SXY2_W  = ptlf_pkg::MEAN_W + ptlf_pkg::VAR_W + LW;
    localparam int SYY2_W  = 2 * ptlf_pkg::VAR_W + LW;
    localparam int DP_W    = ptlf_pkg::DP_W;
    localparam int WORD_W  = ptlf_pkg::WORD_W;

    // input field unpack
    logic [ptlf_pkg::MEAN_W-1:0]        in_mean;
    logic [ptlf_pkg::VAR_W-1:0]         in_var;
    logic                               in_present;
    logic [ptlf_pkg::FRAC_W-1:0]        in_sat;
    logic [ptlf_pkg::FRAC_W-1:0]        in_blk;
    logic signed [ptlf_pkg::LEXP_W-1:0] in_lexp;

    assign in_mean    = s_tdata[19:0];
    assign in_var     = s_tdata[43:20];
    assign in_present = s_tdata[44];
    assign in_sat     = s_tdata[60:45];
    assign in_blk     = s_tdata[76:61];
    assign in_lexp    = s_tdata[92:77];

    // configuration
    logic signed [ptlf_pkg::LEXP_W-1:0] min_lexp_reg;
    logic [ptlf_pkg::MINZ_W-1:0]        min_zones_reg;
    logic [ptlf_pkg::R2_W-1:0]          min_r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_lexp_reg  <= ptlf_pkg::MIN_LEXP_RST;
            min_zones_reg <= ptlf_pkg::MIN_ZONES_RST;
            min_r2_reg    <= ptlf_pkg::MIN_R2_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptlf_pkg::CFG_MIN_LEXP:  min_lexp_reg  <= cfg_data[ptlf_pkg::LEXP_W-1:0];
                ptlf_pkg::CFG_MIN_ZONES: min_zones_reg <= cfg_data[ptlf_pkg::MINZ_W-1:0];
                ptlf_pkg::CFG_MIN_R2:    min_r2_reg    <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // control state
    ptlf_pkg::state_t          state_reg, state_next;
    logic                      issued_reg, issued_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [SX_W-1:0]           sx_reg, sx_next;
    logic [SY_W-1:0]           sy_reg, sy_next;
    logic [SXX2_W-1:0]         sxx2_reg, sxx2_next;
    logic [SXY2_W-1:0]         sxy2_reg, sxy2_next;
    logic [SYY2_W-1:0]         syy2_reg, syy2_next;
    logic                      m_valid_reg, m_valid_next;

    // item and working registers
    logic [ptlf_pkg::MEAN_W-1:0]   x_reg, x_next;
    logic [ptlf_pkg::VAR_W-1:0]    y_reg, y_next;
    logic                          last_reg, last_next;
    ptlf_pkg::zone_status_t        zst_reg, zst_next;
    ptlf_pkg::fit_status_t         fst_reg, fst_next;
    logic [ptlf_pkg::SLOPE_W-1:0]  slope_reg, slope_next;
    logic [ptlf_pkg::SLOPE_W-1:0]  smag_reg, smag_next;
    logic [ptlf_pkg::ICPT_W-1:0]   icpt_reg, icpt_next;
    logic [ptlf_pkg::R2_W-1:0]     r2_reg, r2_next;
    logic [WORD_W-1:0]             p_reg, p_next;
    logic [WORD_W-1:0]             sxx_reg, sxx_next;
    logic [WORD_W-1:0]             syy_reg, syy_next;
    logic [WORD_W-1:0]             mag_reg, mag_next;
    logic                          neg_reg, neg_next;
    logic [WORD_W-1:0]             imag_reg, imag_next;
    logic                          ineg_reg, ineg_next;
    logic [DP_W-1:0]               wa_reg, wa_next;
    logic [DP_W-1:0]               wb_reg, wb_next;
    logic [ptlf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    ptlf_pkg::mdu_req_t mdu_req;
    ptlf_pkg::mdu_rsp_t mdu_rsp;

    ptlf_mdu u_mdu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mdu_req),
        .rsp   (mdu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ptlf_pkg::S_IDLE;
            issued_reg  <= 1'b0;
            count_reg   <= '0;
            sx_reg      <= '0;
            sy_reg      <= '0;
            sxx2_reg    <= '0;
            sxy2_reg    <= '0;
            syy2_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            count_reg   <= count_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
            sxx2_reg    <= sxx2_next;
            sxy2_reg    <= sxy2_next;
            syy2_reg    <= syy2_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        last_reg    <= last_next;
        zst_reg     <= zst_next;
        fst_reg     <= fst_next;
        slope_reg   <= slope_next;
        smag_reg    <= smag_next;
        icpt_reg    <= icpt_next;
        r2_reg      <= r2_next;
        p_reg       <= p_next;
        sxx_reg     <= sxx_next;
        syy_reg     <= syy_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        imag_reg    <= imag_next;
        ineg_reg    <= ineg_next;
        wa_reg      <= wa_next;
        wb_reg      <= wb_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    always_comb
    begin
        logic                          is_op;
        logic [WORD_W-1:0]             res_w;
        logic [WORD_W-1:0]             syy_calc;
        logic [WORD_W-1:0]             sy16;
        logic [ptlf_pkg::MINZ_W:0]     need;
        logic [ptlf_pkg::SLOPE_W-1:0]  scap;
        logic [ptlf_pkg::ICPT_W-1:0]   icap;
        logic [ptlf_pkg::ICPT_W-1:0]   imag_sat;
        logic [ptlf_pkg::R2_W-1:0]     r2_sat;
        logic [ptlf_pkg::NZ_W-1:0]     nz;

        is_op    = 1'b0;
        res_w    = mdu_rsp.result[WORD_W-1:0];
        syy_calc = p_reg - res_w;
        sy16     = WORD_W'(sy_reg) << 16;
        need     = '0;
        scap     = neg_reg ? ptlf_pkg::SLOPE_CAP_NEG : ptlf_pkg::SLOPE_CAP_POS;
        icap     = ineg_reg ? ptlf_pkg::ICPT_CAP_NEG : ptlf_pkg::ICPT_CAP_POS;
        imag_sat = '0;
        r2_sat   = '0;
        nz       = last_reg ? ptlf_pkg::NZ_W'(count_reg) : '0;

        state_next   = state_reg;
        issued_next  = issued_reg;
        count_next   = count_reg;
        sx_next      = sx_reg;
        sy_next      = sy_reg;
        sxx2_next    = sxx2_reg;
        sxy2_next    = sxy2_reg;
        syy2_next    = syy2_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        x_next       = x_reg;
        y_next       = y_reg;
        last_next    = last_reg;
        zst_next     = zst_reg;
        fst_next     = fst_reg;
        slope_next   = slope_reg;
        smag_next    = smag_reg;
        icpt_next    = icpt_reg;
        r2_next      = r2_reg;
        p_next       = p_reg;
        sxx_next     = sxx_reg;
        syy_next     = syy_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        imag_next    = imag_reg;
        ineg_next    = ineg_reg;
        wa_next      = wa_reg;
        wb_next      = wb_reg;
        m_tdata_next = m_tdata_reg;
        m_tuser_next = m_tuser_reg;

        mdu_req.start = 1'b0;
        mdu_req.op    = ptlf_pkg::MDU_MUL;
        mdu_req.a     = '0;
        mdu_req.b     = '0;

        s_tready = (state_reg == ptlf_pkg::S_IDLE);

        case (state_reg)
            ptlf_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = in_mean;
                    y_next     = in_var;
                    last_next  = s_tlast;
                    fst_next   = ptlf_pkg::FS_OK;
                    slope_next = '0;
                    icpt_next  = '0;
                    r2_next    = '0;
                    // first matching exclusion reason wins
                    if (!in_present || in_var == '0)
                        zst_next = ptlf_pkg::ZS_NO_VARIANCE;
                    else if (in_sat != '0)
                        zst_next = ptlf_pkg::ZS_SATURATED;
                    else if (in_blk != '0)
                        zst_next = ptlf_pkg::ZS_BELOW_BLACK;
                    else if (in_lexp < min_lexp_reg)
                        zst_next = ptlf_pkg::ZS_LOW_TAIL;
                    else if (in_mean == '0)
                        zst_next = ptlf_pkg::ZS_NONPOS_MEAN;
                    else
                        zst_next = ptlf_pkg::ZS_INCLUDED;

                    if (zst_next == ptlf_pkg::ZS_INCLUDED && count_reg < CW'(MAX_ZONES))
                        state_next = ptlf_pkg::S_ACC_XX;
                    else if (s_tlast)
                        state_next = ptlf_pkg::S_FIT_CHECK;
                    else
                        state_next = ptlf_pkg::S_OUT;
                end
            end
            ptlf_pkg::S_ACC_XX:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(x_reg);
                mdu_req.b = DP_W'(x_reg);
                if (mdu_rsp.done)
                begin
                    sxx2_next  = sxx2_reg + SXX2_W'(mdu_rsp.result);
                    state_next = ptlf_pkg::S_ACC_XY;
                end
            end
            ptlf_pkg::S_ACC_XY:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(y_reg);
                mdu_req.b = DP_W'(x_reg);
                if (mdu_rsp.done)
                begin
                    sxy2_next  = sxy2_reg + SXY2_W'(mdu_rsp.result);
                    state_next = ptlf_pkg::S_ACC_YY;
                end
            end
            ptlf_pkg::S_ACC_YY:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(y_reg);
                mdu_req.b = DP_W'(y_reg);
                if (mdu_rsp.done)
                begin
                    syy2_next  = syy2_reg + SYY2_W'(mdu_rsp.result);
                    sx_next    = sx_reg + SX_W'(x_reg);
                    sy_next    = sy_reg + SY_W'(y_reg);
                    count_next = count_reg + 1'b1;
                    state_next = last_reg ? ptlf_pkg::S_FIT_CHECK : ptlf_pkg::S_OUT;
                end
            end
            ptlf_pkg::S_FIT_CHECK:
            begin
                need = (min_zones_reg < ptlf_pkg::MIN_ZONES_FLOOR) ?
                       (ptlf_pkg::MINZ_W + 1)'(ptlf_pkg::MIN_ZONES_FLOOR) :
                       (ptlf_pkg::MINZ_W + 1)'(min_zones_reg);
                if ((ptlf_pkg::MINZ_W + 1)'(count_reg) < need)
                begin
                    fst_next   = ptlf_pkg::FS_TOO_FEW;
                    state_next = ptlf_pkg::S_OUT;
                end
                else
                    state_next = ptlf_pkg::S_SXX_A;
            end
            ptlf_pkg::S_SXX_A:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(sxx2_reg);
                mdu_req.b = DP_W'(count_reg);
                if (mdu_rsp.done)
                begin
                    p_next     = res_w;
                    state_next = ptlf_pkg::S_SXX_B;
                end
            end
            ptlf_pkg::S_SXX_B:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(sx_reg);
                mdu_req.b = DP_W'(sx_reg);
                if (mdu_rsp.done)
                begin
                    sxx_next   = p_reg - res_w;
                    state_next = ptlf_pkg::S_SYY_A;
                end
            end
            ptlf_pkg::S_SYY_A:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(syy2_reg);
                mdu_req.b = DP_W'(count_reg);
                if (mdu_rsp.done)
                begin
                    p_next     = res_w;
                    state_next = ptlf_pkg::S_SYY_B;
                end
            end
            ptlf_pkg::S_SYY_B:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(sy_reg);
                mdu_req.b = DP_W'(sy_reg);
                if (mdu_rsp.done)
                begin
                    syy_next = syy_calc;
                    // degenerate spread in either variable
                    if (sxx_reg == '0 || syy_calc == '0)
                    begin
                        fst_next   = ptlf_pkg::FS_NOT_LINEAR;
                        state_next = ptlf_pkg::S_OUT;
                    end
                    else
                        state_next = ptlf_pkg::S_SXY_A;
                end
            end
            ptlf_pkg::S_SXY_A:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(sxy2_reg);
                mdu_req.b = DP_W'(count_reg);
                if (mdu_rsp.done)
                begin
                    p_next     = res_w;
                    state_next = ptlf_pkg::S_SXY_B;
                end
            end
            ptlf_pkg::S_SXY_B:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(sx_reg);
                mdu_req.b = DP_W'(sy_reg);
                if (mdu_rsp.done)
                begin
                    neg_next   = (p_reg < res_w);
                    mag_next   = (p_reg < res_w) ? (res_w - p_reg) : (p_reg - res_w);
                    state_next = ptlf_pkg::S_SLOPE;
                end
            end
            ptlf_pkg::S_SLOPE:
            begin
                // |Sxy| * 2^16 / Sxx, rounded, saturated
                is_op      = 1'b1;
                mdu_req.op = ptlf_pkg::MDU_DIV;
                mdu_req.a  = DP_W'(mag_reg) << 16;
                mdu_req.b  = DP_W'(sxx_reg);
                if (mdu_rsp.done)
                begin
                    smag_next  = (mdu_rsp.result > DP_W'(scap)) ? scap :
                                 mdu_rsp.result[ptlf_pkg::SLOPE_W-1:0];
                    slope_next = neg_reg ? (~smag_next + 1'b1) : smag_next;
                    state_next = ptlf_pkg::S_ICPT_MUL;
                end
            end
            ptlf_pkg::S_ICPT_MUL:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(smag_reg);
                mdu_req.b = DP_W'(sx_reg);
                if (mdu_rsp.done)
                begin
                    // Sy*2^16 - slope*Sx as sign and magnitude
                    if (neg_reg)
                    begin
                        ineg_next = 1'b0;
                        imag_next = sy16 + res_w;
                    end
                    else if (res_w > sy16)
                    begin
                        ineg_next = 1'b1;
                        imag_next = res_w - sy16;
                    end
                    else
                    begin
                        ineg_next = 1'b0;
                        imag_next = sy16 - res_w;
                    end
                    state_next = ptlf_pkg::S_ICPT_DIV;
                end
            end
            ptlf_pkg::S_ICPT_DIV:
            begin
                is_op      = 1'b1;
                mdu_req.op = ptlf_pkg::MDU_DIV;
                mdu_req.a  = DP_W'(imag_reg);
                mdu_req.b  = DP_W'(count_reg) << 16;
                if (mdu_rsp.done)
                begin
                    imag_sat   = (mdu_rsp.result > DP_W'(icap)) ? icap :
                                 mdu_rsp.result[ptlf_pkg::ICPT_W-1:0];
                    icpt_next  = ineg_reg ? (~imag_sat + 1'b1) : imag_sat;
                    state_next = ptlf_pkg::S_R2_NUM;
                end
            end
            ptlf_pkg::S_R2_NUM:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(mag_reg);
                mdu_req.b = DP_W'(mag_reg);
                if (mdu_rsp.done)
                begin
                    wa_next    = mdu_rsp.result;
                    state_next = ptlf_pkg::S_R2_DEN;
                end
            end
            ptlf_pkg::S_R2_DEN:
            begin
                is_op     = 1'b1;
                mdu_req.a = DP_W'(syy_reg);
                mdu_req.b = DP_W'(sxx_reg);
                if (mdu_rsp.done)
                begin
                    wb_next    = mdu_rsp.result;
                    state_next = ptlf_pkg::S_R2_DIV;
                end
            end
            ptlf_pkg::S_R2_DIV:
            begin
                is_op      = 1'b1;
                mdu_req.op = ptlf_pkg::MDU_DIV;
                mdu_req.a  = wa_reg << 16;
                mdu_req.b  = wb_reg;
                if (mdu_rsp.done)
                begin
                    r2_sat  = (mdu_rsp.result > DP_W'(ptlf_pkg::R2_ONE)) ? ptlf_pkg::R2_ONE :
                              mdu_rsp.result[ptlf_pkg::R2_W-1:0];
                    r2_next = r2_sat;
                    // valid only for positive covariance and enough linearity
                    if (!neg_reg && mag_reg != '0 && r2_sat >= min_r2_reg)
                        fst_next = ptlf_pkg::FS_OK;
                    else
                        fst_next = ptlf_pkg::FS_NOT_LINEAR;
                    state_next = ptlf_pkg::S_OUT;
                end
            end
            ptlf_pkg::S_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_tuser_next = last_reg;
                    m_tdata_next = {r2_reg, icpt_reg, slope_reg, nz, fst_reg, zst_reg};
                    if (last_reg)
                    begin
                        count_next = '0;
                        sx_next    = '0;
                        sy_next    = '0;
                        sxx2_next  = '0;
                        sxy2_next  = '0;
                        syy2_next  = '0;
                    end
                    state_next = ptlf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptlf_pkg::S_IDLE;
            end
        endcase

        // one request per operation state, cleared on completion
        mdu_req.start = is_op & ~issued_reg;
        if (mdu_req.start)
            issued_next = 1'b1;
        else if (mdu_rsp.done)
            issued_next = 1'b0;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_mdu_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mdu_req.start |-> !mdu_rsp.busy)
        else $error("arith unit started while busy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ZONES))
        else $error("zone count beyond limit");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ptlf_pkg::S_IDLE)
        else $error("accepted item not processed");

    // a valid fit may round its slope down to zero, but never below
    a_ok_slope_positive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser && m_tdata[4:3] == ptlf_pkg::FS_OK
        |-> !m_tdata[42])
        else $error("valid fit with negative slope");
`endif

endmodule

`default_nettype wire

// ===== verif/photon_transfer_line_fit_test.sv =====
`default_nettype none

// Stream-level testbench for the photon transfer line fit.
// Zone items go in on s_*, one result item per zone comes out on m_*.
// A scoreboard class carries its own copy of the sums and registers,
// predicts each result when a zone is accepted, and compares results
// field by field in arrival order.
module photon_transfer_line_fit_test;

    localparam int WATCHDOG_LIMIT = 6000;  // cycles with no item moving
    localparam int TAIL_CYCLES    = 1000;  // idle time after the final drain
    localparam int RANDOM_ITEMS   = 1900;

    // one expected result item
    typedef struct {
        ptlf_pkg::zone_status_t               zs;
        logic                                 ready;
        ptlf_pkg::fit_status_t                fs;
        logic [ptlf_pkg::NZ_W-1:0]            nz;
        logic [ptlf_pkg::SLOPE_W-1:0]         slope;
        logic [ptlf_pkg::ICPT_W-1:0]          icpt;
        logic [ptlf_pkg::R2_W-1:0]            r2;
    } fit_result_t;

    class fit_scoreboard;
        fit_result_t pending[$];
        int          errors;
        // register copies
        logic signed [ptlf_pkg::LEXP_W-1:0] lexp_floor;
        logic [ptlf_pkg::MINZ_W-1:0]        zone_floor;
        logic [ptlf_pkg::R2_W-1:0]          r2_floor;
        // running sums
        logic [63:0] cnt, sx, sy, sxx2, sxy2, syy2;

        function new();
            errors     = 0;
            lexp_floor = ptlf_pkg::MIN_LEXP_RST;
            zone_floor = ptlf_pkg::MIN_ZONES_RST;
            r2_floor   = ptlf_pkg::MIN_R2_RST;
            clear_sums();
        endfunction

        function void clear_sums();
            cnt = 0; sx = 0; sy = 0; sxx2 = 0; sxy2 = 0; syy2 = 0;
        endfunction

        function void write_reg(logic [ptlf_pkg::CFG_IDX_W-1:0] idx,
                                logic [ptlf_pkg::CFG_DATA_W-1:0] val);
            if (idx == ptlf_pkg::CFG_MIN_LEXP)       lexp_floor = val[ptlf_pkg::LEXP_W-1:0];
            else if (idx == ptlf_pkg::CFG_MIN_ZONES) zone_floor = val[ptlf_pkg::MINZ_W-1:0];
            else if (idx == ptlf_pkg::CFG_MIN_R2)    r2_floor   = val[ptlf_pkg::R2_W-1:0];
        endfunction

        // predict the result of one accepted zone
        function void note_zone(logic [ptlf_pkg::S_TDATA_W-1:0] d, logic last);
            logic [63:0]  x, y, need, sxx, syy, mag, smag, den, imag, icap;
            logic signed [ptlf_pkg::LEXP_W-1:0] lexp;
            longint       sxy, slope_s, numi;
            logic [255:0] wnum, wden, q;
            fit_result_t  r;
            x    = d[19:0];
            y    = d[43:20];
            lexp = d[92:77];
            if (!d[44] || y == 0)       r.zs = ptlf_pkg::ZS_NO_VARIANCE;
            else if (d[60:45] != 0)     r.zs = ptlf_pkg::ZS_SATURATED;
            else if (d[76:61] != 0)     r.zs = ptlf_pkg::ZS_BELOW_BLACK;
            else if (lexp < lexp_floor) r.zs = ptlf_pkg::ZS_LOW_TAIL;
            else if (x == 0)            r.zs = ptlf_pkg::ZS_NONPOS_MEAN;
            else                        r.zs = ptlf_pkg::ZS_INCLUDED;
            // zones past the capacity still report included but add nothing
            if (r.zs == ptlf_pkg::ZS_INCLUDED && cnt < ptlf_pkg::MAX_ZONES_DEF)
            begin
                cnt++;
                sx   += x;
                sy   += y;
                sxx2 += x * x;
                sxy2 += x * y;
                syy2 += y * y;
            end
            r.ready = last;
            r.fs    = ptlf_pkg::FS_OK;
            r.nz    = 0;
            r.slope = 0;
            r.icpt  = 0;
            r.r2    = 0;
            if (last)
            begin
                need = (zone_floor < ptlf_pkg::MIN_ZONES_FLOOR) ?
                       64'(ptlf_pkg::MIN_ZONES_FLOOR) : 64'(zone_floor);
                r.nz = cnt[ptlf_pkg::NZ_W-1:0];
                if (cnt < need)
                begin
                    r.fs = ptlf_pkg::FS_TOO_FEW;
                end
                else
                begin
                    sxx = cnt * sxx2 - sx * sx;
                    syy = cnt * syy2 - sy * sy;
                    sxy = longint'(cnt * sxy2) - longint'(sx * sy);
                    if (sxx == 0 || syy == 0)
                    begin
                        r.fs = ptlf_pkg::FS_NOT_LINEAR;   // degenerate spread
                    end
                    else
                    begin
                        mag  = (sxy < 0) ? 64'(-sxy) : 64'(sxy);
                        // round half up: (2*num*2^16 + den) / (2*den)
                        q    = ((256'(mag) << 17) + 256'(sxx)) / (256'(sxx) << 1);
                        if (sxy < 0) smag = (q > 256'h8000_0000) ? 64'h8000_0000 : q[63:0];
                        else         smag = (q > 256'h7FFF_FFFF) ? 64'h7FFF_FFFF : q[63:0];
                        slope_s = (sxy < 0) ? -longint'(smag) : longint'(smag);
                        numi = longint'(sy << 16) - slope_s * longint'(sx);
                        den  = cnt << 16;
                        imag = (numi < 0) ? 64'(-numi) : 64'(numi);
                        icap = (numi < 0) ? (64'd1 << 35) : ((64'd1 << 35) - 1);
                        imag = (imag + den / 2) / den;
                        if (imag > icap) imag = icap;
                        r.slope = slope_s[ptlf_pkg::SLOPE_W-1:0];
                        r.icpt  = (numi < 0) ? -imag[ptlf_pkg::ICPT_W-1:0] :
                                  imag[ptlf_pkg::ICPT_W-1:0];
                        wnum = 256'(mag) * 256'(mag);
                        wden = 256'(sxx) * 256'(syy);
                        q    = ((wnum << 17) + wden) / (wden << 1);
                        r.r2 = (q > 256'h1_0000) ? ptlf_pkg::R2_ONE : q[ptlf_pkg::R2_W-1:0];
                        r.fs = (sxy > 0 && r.r2 >= r2_floor) ? ptlf_pkg::FS_OK :
                               ptlf_pkg::FS_NOT_LINEAR;
                    end
                end
                clear_sums();
            end
            pending = {pending, r};
        endfunction

        function void check_result(logic [ptlf_pkg::M_TDATA_W-1:0] d, logic user);
            fit_result_t e;
            if (pending.size() == 0)
            begin
                $error("result item with nothing expected: tdata=%h tuser=%b", d, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[2:0] !== e.zs)
            begin
                $error("zone_status expected %0d got %0d", e.zs, d[2:0]); errors++;
            end
            if (user !== e.ready)
            begin
                $error("fit_ready expected %0d got %0d", e.ready, user); errors++;
            end
            if (d[4:3] !== e.fs)
            begin
                $error("fit_status expected %0d got %0d", e.fs, d[4:3]); errors++;
            end
            if (d[10:5] !== e.nz)
            begin
                $error("fitted_zones expected %0d got %0d", e.nz, d[10:5]); errors++;
            end
            if (d[42:11] !== e.slope)
            begin
                $error("fit_slope expected %h got %h", e.slope, d[42:11]); errors++;
            end
            if (d[78:43] !== e.icpt)
            begin
                $error("fit_intercept expected %h got %h", e.icpt, d[78:43]); errors++;
            end
            if (d[95:79] !== e.r2)
            begin
                $error("fit_r_squared expected %h got %h", e.r2, d[95:79]); errors++;
            end
        endfunction
    endclass

    logic                                clk, rst_n;
    logic                                s_tvalid, s_tready, s_tlast;
    logic [ptlf_pkg::S_TDATA_W-1:0]      s_tdata;
    logic                                m_tvalid, m_tready, m_tuser;
    logic [ptlf_pkg::M_TDATA_W-1:0]      m_tdata;
    logic                                cfg_we;
    logic [ptlf_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [ptlf_pkg::CFG_DATA_W-1:0]     cfg_data;

    fit_scoreboard sb;
    int  gap_pct, stall_pct;   // idle odds per hundred, sender and receiver
    int  sent;
    int  quiet_cycles;
    // line shape for clean runs
    int  line_k, line_c, line_noise;
    bit  line_down;

    photon_transfer_line_fit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    // receiver: random backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // result monitor; values read here are the pre-edge ones
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    // watchdog: any handshake resets the count
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [ptlf_pkg::S_TDATA_W-1:0] pack_zone(logic [19:0] mean,
            logic [23:0] var_q, logic pres, logic [15:0] sat, logic [15:0] blk,
            logic [15:0] lexp);
        return {3'b000, lexp, blk, sat, pres, var_q, mean};
    endfunction

    // one item through the input handshake; tvalid stays up after the
    // accepting edge and is dropped by the next gap or by drain
    task automatic send_zone(logic [ptlf_pkg::S_TDATA_W-1:0] d, logic last);
        while ($urandom_range(99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_zone(d, last);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [ptlf_pkg::CFG_IDX_W-1:0] idx,
                             logic [ptlf_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // a zone that lands on the current line, above the exposure floor
    function automatic logic [ptlf_pkg::S_TDATA_W-1:0] clean_zone();
        logic [63:0] m, v;
        int          lo;
        m  = $urandom_range(1, (1 << $urandom_range(4, 20)) - 1);
        v  = (m * line_k) >> 4;
        v  = line_down ? ((line_c > v) ? line_c - v : 1) : v + line_c;
        v += $urandom_range(0, line_noise);
        if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
        if (v == 0) v = 1;
        lo = sb.lexp_floor;
        return pack_zone(m[19:0], v[23:0], 1'b1, 16'd0, 16'd0,
                         16'($urandom_range(lo + 32768, 65535) - 32768));
    endfunction

    // any field may take any value; zeros are favored so every status shows up
    function automatic logic [ptlf_pkg::S_TDATA_W-1:0] noise_zone();
        return pack_zone(($urandom_range(3) == 0) ? 20'd0 : 20'($urandom),
                         ($urandom_range(4) == 0) ? 24'd0 : 24'($urandom),
                         ($urandom_range(4) != 0),
                         ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom),
                         ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom),
                         16'($urandom));
    endfunction

    task automatic new_line();
        line_k     = $urandom_range(1, 4096);
        line_c     = $urandom_range(0, 1 << $urandom_range(0, 23));
        line_down  = ($urandom_range(9) == 0);
        case ($urandom_range(2))
            0: line_noise = 0;
            1: line_noise = $urandom_range(0, 64);
            default: line_noise = $urandom_range(0, 1 << 22);
        endcase
    endtask

    // one plane: n zones, a share of them noise
    task automatic send_run(int n, int noise_pct);
        new_line();
        for (int i = 0; i < n; i++)
            send_zone(($urandom_range(99) < noise_pct) ? noise_zone() : clean_zone(),
                      i == n - 1);
    endtask

    task automatic set_phase(int p);
        case (p % 4)
            0:
            begin
                gap_pct = 0;  stall_pct = 0;
            end
            1:
            begin
                gap_pct = 71; stall_pct = 0;
            end
            2:
            begin
                gap_pct = 0;  stall_pct = 71;
            end
            default:
            begin
                gap_pct = 21; stall_pct = 21;
            end
        endcase
        // phase 0 runs on the reset defaults
        case (p)
            1:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'h08000);
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd2);
                write_reg(ptlf_pkg::CFG_MIN_R2, 17'd0);
            end
            2:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'h07FFF);
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd32);
                write_reg(ptlf_pkg::CFG_MIN_R2, ptlf_pkg::R2_ONE);
            end
            3:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'd0);
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd0);
                write_reg(ptlf_pkg::CFG_MIN_R2, 17'h1FFFF);
            end
            4:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'(16'(-6554)));
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd63);
                write_reg(ptlf_pkg::CFG_MIN_R2, 17'd58982);
            end
            5:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'hC000);
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd3);
                write_reg(ptlf_pkg::CFG_MIN_R2, ptlf_pkg::R2_ONE);
            end
            6:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'd4096);
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd4);
                write_reg(ptlf_pkg::CFG_MIN_R2, 17'd30000);
            end
            7:
            begin
                write_reg(ptlf_pkg::CFG_MIN_LEXP, 17'(16'(-6554)));
                write_reg(ptlf_pkg::CFG_MIN_ZONES, 17'd5);
                write_reg(ptlf_pkg::CFG_MIN_R2, 17'd58982);
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int roll;
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_pct   = 0;
        stall_pct = 0;
        sent      = 0;
        quiet_cycles = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each exclusion, then a last zone with too few included
        send_zone(pack_zone(20'd100, 24'd50, 1'b0, 16'd0, 16'd0, 16'd0), 1'b0);
        send_zone(pack_zone(20'd100, 24'd0, 1'b1, 16'd0, 16'd0, 16'd0), 1'b0);
        send_zone(pack_zone(20'd100, 24'd50, 1'b1, 16'hFFFF, 16'd0, 16'd0), 1'b0);
        send_zone(pack_zone(20'd100, 24'd50, 1'b1, 16'd0, 16'hFFFF, 16'd0), 1'b0);
        send_zone(pack_zone(20'd100, 24'd50, 1'b1, 16'd0, 16'd0, 16'h8000), 1'b0);
        send_zone(pack_zone(20'd0, 24'd50, 1'b1, 16'd0, 16'd0, 16'h7FFF), 1'b0);
        send_zone(pack_zone(20'hFFFFF, 24'hFFFFFF, 1'b1, 16'd0, 16'd0, 16'h7FFF), 1'b1);
        // empty plane: last zone excluded, nothing included
        send_zone(pack_zone(20'd0, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0), 1'b1);
        // degenerate spread: the same mean every zone
        for (int i = 0; i < 5; i++)
            send_zone(pack_zone(20'd4000, 24'(1000 + 7 * i), 1'b1, 16'd0, 16'd0, 16'd0),
                      i == 4);
        // exact line with extremes of mean and variance
        for (int i = 0; i < 5; i++)
            send_zone(pack_zone(20'hFFFFF >> (4 * i), 24'hFFFFFF >> (4 * i), 1'b1,
                                16'd0, 16'd0, 16'd0), i == 4);
        // falling line: slope below zero
        for (int i = 0; i < 6; i++)
            send_zone(pack_zone(20'(1000 * (i + 1)), 24'(90000 - 9000 * i), 1'b1,
                                16'd0, 16'd0, 16'd0), i == 5);

        // random planes over several register settings and idling phases
        for (int p = 0; p < 8; p++)
        begin
            drain();
            set_phase(p);
            while (sent < (p + 1) * RANDOM_ITEMS / 8 + 25)
            begin
                roll = $urandom_range(99);
                if (roll < 80)      send_run($urandom_range(2, 12), 10);
                else if (roll < 93) send_run($urandom_range(1, 6), 100);
                else                send_run($urandom_range(33, 40), 0);  // overflow
                // let the pipe run dry now and then
                if ($urandom_range(19) == 0) drain();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
